>>> design/ab_blit_pkg.sv
// ----------------------------------------------------------------------------
// ab_blit_pkg
// shared widths, register indexes and the divide-by-255 helper for the
// alpha blend blitter
// ----------------------------------------------------------------------------
package ab_blit_pkg;

   localparam int CHAN_W   = 8;
   localparam int ARGB_W   = 32;
   localparam int RGB_W    = 24;
   localparam int ADDR_W   = 24;
   localparam int COORD_W  = 12;
   localparam int SIZE_W   = 13;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 13;
   localparam int REQ_DATA_W = 56;
   localparam int RSP_DATA_W = 48;
   localparam int NUM_CHAN = 3;

   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_WIDTH  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SPRITE_HEIGHT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_WIDTH  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SCREEN_HEIGHT = 3'd5;

   localparam logic [COORD_W-1:0] ORIGIN_RESET        = 12'd0;
   localparam logic [SIZE_W-1:0]  SPRITE_SIZE_RESET   = 13'd1;
   localparam logic [SIZE_W-1:0]  SCREEN_WIDTH_RESET  = 13'd640;
   localparam logic [SIZE_W-1:0]  SCREEN_HEIGHT_RESET = 13'd480;

   // floor(p / 255) for p up to 255 * 255, by the usual add-and-shift trick
   function automatic logic [CHAN_W-1:0] div255(input logic [2*CHAN_W-1:0] p);
      logic [2*CHAN_W:0] t;
      t = (2*CHAN_W+1)'(p) + (2*CHAN_W+1)'(p[2*CHAN_W-1:CHAN_W]) + 17'd1;
      return t[2*CHAN_W-1:CHAN_W];
   endfunction

endpackage

>>> design/ab_blit_blend.sv
// ----------------------------------------------------------------------------
// ab_blit_blend
// per-channel alpha mix of a sprite pixel over a background pixel
// ----------------------------------------------------------------------------
module ab_blit_blend (
   input  logic [ab_blit_pkg::ARGB_W-1:0] src_argb,
   input  logic [ab_blit_pkg::RGB_W-1:0]  bg_rgb,
   output logic [ab_blit_pkg::RGB_W-1:0]  blended_rgb
);

   localparam int CW = ab_blit_pkg::CHAN_W;

   logic [CW-1:0] alpha;
   logic [CW-1:0] alpha_inv;

   assign alpha     = src_argb[ab_blit_pkg::ARGB_W-1 -: CW];
   assign alpha_inv = ab_blit_pkg::CHAN_MAX - alpha;

   for (genvar ch = 0; ch < ab_blit_pkg::NUM_CHAN; ch++) begin : g_chan
      logic [2*CW-1:0] src_term;
      logic [2*CW-1:0] bg_term;
      logic [CW:0]     mix_sum;

      // each term truncated on its own; the sum never passes 255
      assign src_term = src_argb[ch*CW +: CW] * alpha;
      assign bg_term  = bg_rgb[ch*CW +: CW] * alpha_inv;
      assign mix_sum  = (CW+1)'(ab_blit_pkg::div255(src_term))
                      + (CW+1)'(ab_blit_pkg::div255(bg_term));
      assign blended_rgb[ch*CW +: CW] = mix_sum[CW-1:0];
   end

endmodule

>>> design/alpha_blend_blitter.sv
// ----------------------------------------------------------------------------
// alpha_blend_blitter
// ARGB8888 sprite blitter with per-pixel alpha blend and frame-buffer address
// ----------------------------------------------------------------------------
// One sprite pixel per clock: a beat is taken on every cycle that the result
// side keeps up, and each beat passes from an input register through the
// blend, the address multiply and the bounds test in one pass
// into the result register. The result register lets a new beat be taken
// while a finished one still waits, and req_tready follows rsp_tready within
// the same cycle. Pixels arrive in raster order; the column and row counters
// wrap at the configured sprite size, so rsp_tlast marks the last pixel of
// each sprite and the next beat starts a new one. Sprite sizes of 0 act as 1
// and sizes above MAX_DIM act as MAX_DIM. Pixels that fall off the screen
// come out with rsp_tuser low and a zero address. Write the registers only
// while no beat is in flight.
// ----------------------------------------------------------------------------
module alpha_blend_blitter #(
   parameter int MAX_DIM = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // src_argb [31:0], bg_rgb [55:32]
   input  logic [ab_blit_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // dest_address [23:0], blended_rgb [47:24]
   output logic [ab_blit_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // write_enable [0]
   output logic                                rsp_tuser,
   output logic                                rsp_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic                                csr_we,
   input  logic [ab_blit_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ab_blit_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int COORD_W = ab_blit_pkg::COORD_W;
   localparam int SIZE_W  = ab_blit_pkg::SIZE_W;
   localparam int ADDR_W  = ab_blit_pkg::ADDR_W;
   localparam int RGB_W   = ab_blit_pkg::RGB_W;
   localparam int ARGB_W  = ab_blit_pkg::ARGB_W;
   // counter width, and a width that can hold MAX_DIM itself
   localparam int NW   = $clog2(MAX_DIM);
   localparam int CW   = $clog2(MAX_DIM + 1);
   localparam int SZW  = (CW > SIZE_W) ? CW : SIZE_W;
   localparam int XW   = ((COORD_W > NW) ? COORD_W : NW) + 1;
   localparam int CMPW = (XW > SIZE_W) ? XW : SIZE_W;

   // configuration
   logic [COORD_W-1:0] origin_x_ff, origin_y_ff;
   logic [SIZE_W-1:0]  sprite_width_ff, sprite_height_ff;
   logic [SIZE_W-1:0]  screen_width_ff, screen_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff      <= ab_blit_pkg::ORIGIN_RESET;
         origin_y_ff      <= ab_blit_pkg::ORIGIN_RESET;
         sprite_width_ff  <= ab_blit_pkg::SPRITE_SIZE_RESET;
         sprite_height_ff <= ab_blit_pkg::SPRITE_SIZE_RESET;
         screen_width_ff  <= ab_blit_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= ab_blit_pkg::SCREEN_HEIGHT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            ab_blit_pkg::CSR_ORIGIN_X:      origin_x_ff      <= csr_wdata[COORD_W-1:0];
            ab_blit_pkg::CSR_ORIGIN_Y:      origin_y_ff      <= csr_wdata[COORD_W-1:0];
            ab_blit_pkg::CSR_SPRITE_WIDTH:  sprite_width_ff  <= csr_wdata[SIZE_W-1:0];
            ab_blit_pkg::CSR_SPRITE_HEIGHT: sprite_height_ff <= csr_wdata[SIZE_W-1:0];
            ab_blit_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata[SIZE_W-1:0];
            ab_blit_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sprite size: zero acts as one, capped at MAX_DIM
   logic [SZW-1:0] sw_ext, sh_ext;
   logic [CW-1:0]  spr_w, spr_h;
   logic [CW-1:0]  spr_w_m1, spr_h_m1;

   always_comb begin
      sw_ext = SZW'(sprite_width_ff);
      sh_ext = SZW'(sprite_height_ff);
      if (sw_ext == '0)
         spr_w = CW'(1);
      else if (sw_ext > SZW'(MAX_DIM))
         spr_w = CW'(MAX_DIM);
      else
         spr_w = sw_ext[CW-1:0];
      if (sh_ext == '0)
         spr_h = CW'(1);
      else if (sh_ext > SZW'(MAX_DIM))
         spr_h = CW'(MAX_DIM);
      else
         spr_h = sh_ext[CW-1:0];
      spr_w_m1 = spr_w - CW'(1);
      spr_h_m1 = spr_h - CW'(1);
   end

   // handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic advance;
   logic req_take;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance || !s1_valid_ff;
   assign req_take   = req_tvalid && req_tready;

   // raster counters, stepped on every accepted beat
   logic [NW-1:0] col_ff, row_ff, col_in, row_in;
   logic [NW:0]   col_inc, row_inc;

   always_comb begin
      col_inc = {1'b0, col_ff} + (NW+1)'(1);
      row_inc = {1'b0, row_ff} + (NW+1)'(1);
      col_in  = col_ff;
      row_in  = row_ff;
      if (req_take) begin
         if (col_inc >= (NW+1)'(spr_w)) begin
            col_in = '0;
            if (row_inc >= (NW+1)'(spr_h))
               row_in = '0;
            else
               row_in = row_inc[NW-1:0];
         end else begin
            col_in = col_inc[NW-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // input register
   logic [ARGB_W-1:0] s1_src_ff;
   logic [RGB_W-1:0]  s1_bg_ff;
   logic [NW-1:0]     s1_col_ff, s1_row_ff;

   always_ff @(posedge clock) begin
      if (reset)
         s1_valid_ff <= 1'b0;
      else if (req_tready)
         s1_valid_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_src_ff <= req_tdata[ARGB_W-1:0];
         s1_bg_ff  <= req_tdata[ARGB_W +: RGB_W];
         s1_col_ff <= col_ff;
         s1_row_ff <= row_ff;
      end
   end

   // single pass: blend, destination, bounds test and end-of-sprite
   logic [RGB_W-1:0]  rgb_in;
   logic [XW-1:0]     dest_x, dest_y;
   logic              inside_in;
   logic              last_in;
   logic [ADDR_W-1:0] row_base;
   logic [ADDR_W-1:0] addr_in;

   ab_blit_blend u_blend (
      .src_argb    (s1_src_ff),
      .bg_rgb      (s1_bg_ff),
      .blended_rgb (rgb_in)
   );

   always_comb begin
      dest_x    = XW'(origin_x_ff) + XW'(s1_col_ff);
      dest_y    = XW'(origin_y_ff) + XW'(s1_row_ff);
      inside_in = (CMPW'(dest_x) < CMPW'(screen_width_ff))
               && (CMPW'(dest_y) < CMPW'(screen_height_ff));
      // address kept modulo 2^24
      row_base  = ADDR_W'(dest_y) * ADDR_W'(screen_width_ff);
      addr_in   = inside_in ? (row_base + ADDR_W'(dest_x)) : '0;
      last_in   = ({1'b0, s1_col_ff} == (NW+1)'(spr_w_m1))
               && ({1'b0, s1_row_ff} == (NW+1)'(spr_h_m1));
   end

   // result register
   logic              rsp_we_ff;
   logic              rsp_last_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic [RGB_W-1:0]  rsp_rgb_ff;

   always_ff @(posedge clock) begin
      if (reset)
         rsp_valid_ff <= 1'b0;
      else if (advance)
         rsp_valid_ff <= s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (advance && s1_valid_ff) begin
         rsp_we_ff   <= inside_in;
         rsp_last_ff <= last_in;
         rsp_addr_ff <= addr_in;
         rsp_rgb_ff  <= rgb_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_we_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {rsp_rgb_ff, rsp_addr_ff};

endmodule
